FILE: hw/rtl/mce_pkg.sv
// shared types, byte codes and helper functions of the conductor event encoder
// no dependencies
`default_nettype none

package mce_pkg;

    localparam int TICK_W     = 32;
    localparam int VLQ_GROUPS = 5;
    localparam int VLQ_W      = VLQ_GROUPS * 7;
    localparam int BPM_W      = 10;
    localparam int DIV_W      = 26;
    localparam int DIV_STEPS  = DIV_W;

    localparam logic [DIV_W-1:0] USEC_PER_MIN = 26'd60000000;
    localparam logic [23:0]      MAX24        = 24'hFFFFFF;

    localparam logic [7:0] META_PREFIX    = 8'hFF;
    localparam logic [7:0] META_TIME_SIG  = 8'h58;
    localparam logic [7:0] TIME_SIG_LEN   = 8'h04;
    localparam logic [7:0] MIDI_CLOCKS    = 8'd24;
    localparam logic [7:0] THIRTYSECONDS  = 8'd8;
    localparam logic [7:0] META_TEMPO     = 8'h51;
    localparam logic [7:0] TEMPO_LEN      = 8'h03;
    localparam logic [7:0] META_EOT       = 8'h2F;
    localparam logic [7:0] ZERO_BYTE      = 8'h00;
    localparam logic [7:0] VLQ_CONT       = 8'h80;
    localparam logic [6:0] VLQ_MASK       = 7'h7F;

    typedef struct packed {
        logic              command;
        logic [TICK_W-1:0] tick;
        logic              has_metre;
        logic [7:0]        numerator;
        logic [7:0]        denominator;
        logic              has_tempo;
        logic [BPM_W-1:0]  tempo_bpm;
    } t_evt;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } t_byte;

    // classified item handed from the front to the back
    typedef struct packed {
        logic             is_end;
        logic             has_metre;
        logic             has_tempo;
        logic [VLQ_W-1:0] delta;
        logic [2:0]       vlq_top;
        logic [7:0]       numerator;
        logic [2:0]       den_log2;
        logic [BPM_W-1:0] bpm;
    } t_job;

    typedef struct packed {
        logic             start;
        logic [BPM_W-1:0] bpm;
    } t_div_req;

    typedef struct packed {
        logic        busy;
        logic [23:0] quotient;
    } t_div_stat;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_END,
        BK_M_DELTA,
        BK_M_BODY,
        BK_T_DELTA,
        BK_T_BODY
    } t_back_state;

    function automatic logic [2:0] floor_log2(input logic [7:0] d);
        logic [2:0] p;
        p = 3'd0;
        for (int i = 1; i < 8; i++) begin
            if (d[i]) begin
                p = 3'(i);
            end
        end
        return p;
    endfunction

    // index of the most significant non-zero 7-bit group, 0 for a zero value
    function automatic logic [2:0] vlq_top_group(input logic [VLQ_W-1:0] v);
        logic [2:0] top;
        top = 3'd0;
        for (int g = 1; g < VLQ_GROUPS; g++) begin
            if (v[g*7 +: 7] != 7'd0) begin
                top = 3'(g);
            end
        end
        return top;
    endfunction

    function automatic logic [6:0] vlq_group(input logic [VLQ_W-1:0] v, input logic [2:0] g);
        logic [6:0] grp;
        grp = 7'd0;
        for (int i = 0; i < VLQ_GROUPS; i++) begin
            if (g == 3'(i)) begin
                grp = v[i*7 +: 7] & VLQ_MASK;
            end
        end
        return grp;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/mce_stream_if.sv
// valid/ready stream channel with a typed payload
// payload types come from mce_pkg
`default_nettype none

interface mce_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/mce_front.sv
// front end: accepts event transactions, tracks the tick cursor, classifies into jobs
// depends on mce_pkg, mce_stream_if
`default_nettype none

module mce_front #(
    parameter int TICK_BITS = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    mce_stream_if.sink         i_evt,
    output mce_pkg::t_job      o_job,
    output logic               o_push,
    input  wire logic          i_full
);
    import mce_pkg::*;

    logic [TICK_BITS-1:0] r_cursor;
    logic [TICK_BITS-1:0] n_cursor;
    logic [TICK_BITS-1:0] w_tick;
    logic [TICK_BITS-1:0] w_delta;
    logic [VLQ_W-1:0]     w_delta_ext;
    logic                 w_accept;
    t_evt                 w_evt;

    assign w_evt       = i_evt.payload;
    assign i_evt.ready = !i_full;
    assign w_accept    = i_evt.valid && !i_full;
    assign w_tick      = w_evt.tick[TICK_BITS-1:0];
    assign w_delta     = w_tick - r_cursor;
    assign w_delta_ext = VLQ_W'(w_delta);

    always_comb begin
        o_job.is_end    = w_evt.command;
        o_job.has_metre = w_evt.has_metre;
        o_job.has_tempo = w_evt.has_tempo;
        o_job.delta     = w_delta_ext;
        o_job.vlq_top   = vlq_top_group(w_delta_ext);
        o_job.numerator = w_evt.numerator;
        o_job.den_log2  = floor_log2(w_evt.denominator);
        o_job.bpm       = w_evt.tempo_bpm;
    end

    // empty events are taken but leave no job behind
    assign o_push = w_accept && (w_evt.command || w_evt.has_metre || w_evt.has_tempo);

    always_comb begin
        n_cursor = r_cursor;
        if (w_accept) begin
            if (w_evt.command) begin
                n_cursor = '0;
            end else if (w_evt.has_metre || w_evt.has_tempo) begin
                n_cursor = w_tick;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
        end else begin
            r_cursor <= n_cursor;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/mce_queue.sv
// two-entry job queue between front and back
// depends on mce_pkg
`default_nettype none

module mce_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  mce_pkg::t_job      i_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output mce_pkg::t_job      o_data,
    output logic               o_empty
);
    import mce_pkg::*;

    t_job       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/mce_divider.sv
// restoring divider for the tempo value, one quotient bit per cycle
// depends on mce_pkg
`default_nettype none

module mce_divider (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  mce_pkg::t_div_req   i_req,
    output mce_pkg::t_div_stat  o_stat
);
    import mce_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic [DIV_W-1:0] r_dvd;
    logic [BPM_W-1:0] r_rem;
    logic [BPM_W-1:0] r_bpm;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic [BPM_W:0]   w_rem_sh;
    logic             w_ge;
    logic [BPM_W:0]   w_rem_sub;

    assign w_rem_sh  = {r_rem, r_dvd[DIV_W-1]};
    assign w_ge      = (w_rem_sh >= {1'b0, r_bpm});
    assign w_rem_sub = w_rem_sh - {1'b0, r_bpm};

    // dividend bits shift out at the top while quotient bits shift in below;
    // a zero divisor gives all ones, which saturates like a slow tempo
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= USEC_PER_MIN + DIV_W'(i_req.bpm >> 1);
            r_rem <= '0;
            r_bpm <= i_req.bpm;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DIV_W-2:0], w_ge};
            r_rem <= w_ge ? w_rem_sub[BPM_W-1:0] : w_rem_sh[BPM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_stat.busy     = r_busy;
    assign o_stat.quotient = (r_dvd > DIV_W'(MAX24)) ? MAX24 : r_dvd[23:0];

endmodule

`default_nettype wire

FILE: hw/rtl/mce_back.sv
// back end: byte sequencer that turns jobs into track bytes through an output register
// depends on mce_pkg, mce_stream_if
`default_nettype none

module mce_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  mce_pkg::t_job       i_job,
    input  wire logic           i_empty,
    output logic                o_pop,
    output mce_pkg::t_div_req   o_div_req,
    input  mce_pkg::t_div_stat  i_div_stat,
    mce_stream_if.source        o_byte
);
    import mce_pkg::*;

    t_back_state r_state;
    t_back_state n_state;
    logic [2:0]  r_idx;
    logic [2:0]  n_idx;
    t_job        r_job;
    logic        r_out_valid;
    t_byte       r_out;

    logic        w_emit;
    logic        w_fire;
    logic [7:0]  w_byte;
    logic        w_last;
    logic        w_slot;

    assign w_slot = !r_out_valid || o_byte.ready;
    assign w_fire = w_emit && w_slot;

    // next state
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    n_idx = 3'd0;
                    if (i_job.is_end) begin
                        n_state = BK_END;
                    end else if (i_job.has_metre) begin
                        n_state = BK_M_DELTA;
                        n_idx   = i_job.vlq_top;
                    end else begin
                        n_state = BK_T_DELTA;
                        n_idx   = i_job.vlq_top;
                    end
                end
            end
            BK_END: begin
                if (w_fire) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd3) begin
                        n_state = BK_IDLE;
                    end
                end
            end
            BK_M_DELTA: begin
                if (w_fire) begin
                    n_idx = r_idx - 3'd1;
                    if (r_idx == 3'd0) begin
                        n_state = BK_M_BODY;
                        n_idx   = 3'd0;
                    end
                end
            end
            BK_M_BODY: begin
                if (w_fire) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd6) begin
                        // tempo right after a metre has a zero delta
                        n_state = r_job.has_tempo ? BK_T_DELTA : BK_IDLE;
                        n_idx   = 3'd0;
                    end
                end
            end
            BK_T_DELTA: begin
                if (w_fire) begin
                    n_idx = r_idx - 3'd1;
                    if (r_idx == 3'd0) begin
                        n_state = BK_T_BODY;
                        n_idx   = 3'd0;
                    end
                end
            end
            BK_T_BODY: begin
                if (w_fire) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd5) begin
                        n_state = BK_IDLE;
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
                n_idx   = 3'd0;
            end
        endcase
    end

    // outputs
    always_comb begin
        w_emit          = 1'b0;
        w_byte          = ZERO_BYTE;
        w_last          = 1'b0;
        o_pop           = 1'b0;
        o_div_req.start = 1'b0;
        o_div_req.bpm   = i_job.bpm;
        unique case (r_state)
            BK_IDLE: begin
                o_pop           = !i_empty;
                o_div_req.start = !i_empty && !i_job.is_end && i_job.has_tempo;
            end
            BK_END: begin
                w_emit = 1'b1;
                w_last = (r_idx == 3'd3);
                case (r_idx)
                    3'd1:    w_byte = META_PREFIX;
                    3'd2:    w_byte = META_EOT;
                    default: w_byte = ZERO_BYTE;
                endcase
            end
            BK_M_DELTA: begin
                w_emit = 1'b1;
                w_byte = {(r_idx != 3'd0), vlq_group(r_job.delta, r_idx)};
            end
            BK_M_BODY: begin
                w_emit = 1'b1;
                w_last = (r_idx == 3'd6) && !r_job.has_tempo;
                case (r_idx)
                    3'd0:    w_byte = META_PREFIX;
                    3'd1:    w_byte = META_TIME_SIG;
                    3'd2:    w_byte = TIME_SIG_LEN;
                    3'd3:    w_byte = r_job.numerator;
                    3'd4:    w_byte = {5'd0, r_job.den_log2};
                    3'd5:    w_byte = MIDI_CLOCKS;
                    default: w_byte = THIRTYSECONDS;
                endcase
            end
            BK_T_DELTA: begin
                w_emit = 1'b1;
                if (r_job.has_metre) begin
                    w_byte = ZERO_BYTE;
                end else begin
                    w_byte = {(r_idx != 3'd0), vlq_group(r_job.delta, r_idx)};
                end
            end
            BK_T_BODY: begin
                // hold the tempo value bytes until the divider is through
                w_emit = (r_idx < 3'd3) || !i_div_stat.busy;
                w_last = (r_idx == 3'd5);
                case (r_idx)
                    3'd0:    w_byte = META_PREFIX;
                    3'd1:    w_byte = META_TEMPO;
                    3'd2:    w_byte = TEMPO_LEN;
                    3'd3:    w_byte = i_div_stat.quotient[23:16];
                    3'd4:    w_byte = i_div_stat.quotient[15:8];
                    default: w_byte = i_div_stat.quotient[7:0];
                endcase
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_idx       <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_byte.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (w_fire) begin
            r_out.out_byte <= w_byte;
            r_out.last     <= w_last;
        end
    end

    assign o_byte.valid   = r_out_valid;
    assign o_byte.payload = r_out;

endmodule

`default_nettype wire

FILE: hw/rtl/midi_conductor_event_encoder.sv
// Conductor track event encoder: tempo and time signature events in, track bytes out.
// i_evt carries one event or end command per transaction; o_byte carries one track
// body byte per transaction, with last set on the final byte of that event.
// A time signature gives its delta as a 1..5 byte VLQ and then FF 58 04 nn dd 18 08;
// a tempo gives its delta (00 after a metre at the same event) and FF 51 03 tt tt tt.
// An end command gives 00 FF 2F 00 and returns the tick cursor to zero.
// An event's first byte passes the job queue, sequencer state and output register.
// Throughput: one byte per cycle while o_byte is ready, save for the dequeue and
// divider waits; each item is dequeued in the idle state, then gives its bytes (4 for
// an end, 8..12 for a metre). A tempo value waits on the bit-serial divider, started
// at dequeue. A two-entry job queue lets i_evt keep taking events while the byte
// sequencer runs; events with no metre and no tempo are taken and give nothing.
// Reset clears the cursor, the queue, the divider and the sequencer.
// When o_byte stalls the output register holds; the sequencer waits, then the
// queue fills and i_evt.ready drops.
// depends on mce_pkg, mce_stream_if, mce_front, mce_queue, mce_divider, mce_back
`default_nettype none

module midi_conductor_event_encoder #(
    parameter int TICK_BITS = 32
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    mce_stream_if.sink   i_evt,
    mce_stream_if.source o_byte
);
    import mce_pkg::*;

    t_job      w_push_job;
    t_job      w_head_job;
    logic      w_push;
    logic      w_full;
    logic      w_pop;
    logic      w_empty;
    t_div_req  w_div_req;
    t_div_stat w_div_stat;

    mce_front #(
        .TICK_BITS (TICK_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (i_evt),
        .o_job   (w_push_job),
        .o_push  (w_push),
        .i_full  (w_full)
    );

    mce_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_head_job),
        .o_empty (w_empty)
    );

    mce_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_stat  (w_div_stat)
    );

    mce_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (w_head_job),
        .i_empty    (w_empty),
        .o_pop      (w_pop),
        .o_div_req  (w_div_req),
        .i_div_stat (w_div_stat),
        .o_byte     (o_byte)
    );

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("job pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("job popped from an empty queue");

    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_req.start |-> !w_div_stat.busy)
        else $error("divider restarted while busy");

    a_div_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_req.start |=> w_div_stat.busy)
        else $error("divider did not start");
`endif

endmodule

`default_nettype wire

FILE: verif/tb_midi_conductor_event_encoder.sv
// testbench for midi_conductor_event_encoder: tempo and time signature events in,
// predicted track body bytes checked in order against o_byte
// depends on mce_pkg, mce_stream_if and the encoder rtl
`default_nettype none

module tb_midi_conductor_event_encoder;
    import mce_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 40;
    localparam int RANDOM_ITEMS = 80;
    localparam int CALM_ITEMS = 20;

    logic clk = 1'b0;
    logic rst_n;

    mce_stream_if #(.t_payload(t_evt))  evt_if ();
    mce_stream_if #(.t_payload(t_byte)) byte_if ();

    midi_conductor_event_encoder dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_evt   (evt_if),
        .o_byte  (byte_if)
    );

    t_byte       track_q[$];
    logic [31:0] cursor_tick;
    logic [31:0] last_tick;
    bit          idle_on;
    int          mismatch_count;
    int          byte_count;
    int          stall_left;
    int          quiet_cycles;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ---------------- prediction ----------------

    function automatic void put_track_byte(input logic [7:0] b);
        t_byte tb_byte;
        tb_byte.out_byte = b;
        tb_byte.last = 1'b0;
        track_q = {track_q, tb_byte};
    endfunction

    // most significant group first, continuation bit on all but the final one
    function automatic void put_delta_vlq(input logic [31:0] delta);
        logic [6:0]  grp [5];
        logic [31:0] rest;
        int          cnt;
        rest = delta;
        cnt = 0;
        do begin
            grp[cnt] = rest[6:0];
            rest = rest >> 7;
            cnt++;
        end while (rest != 0 && cnt < 5);
        for (int i = cnt - 1; i >= 0; i--) begin
            put_track_byte({i != 0, grp[i]});
        end
    endfunction

    function automatic logic [7:0] denom_exponent(input logic [7:0] d);
        logic [7:0] p;
        p = 8'd0;
        for (int i = 1; i < 8; i++) begin
            if (d[i]) begin
                p = 8'(i);
            end
        end
        return p;
    endfunction

    function automatic logic [23:0] tempo_usec(input logic [BPM_W-1:0] bpm);
        int unsigned q;
        if (bpm == '0) begin
            return MAX24;
        end
        q = (32'(USEC_PER_MIN) + 32'(bpm) / 2) / 32'(bpm);
        return (q > 32'(MAX24)) ? MAX24 : q[23:0];
    endfunction

    function automatic void encode_event(input t_evt e);
        int          first;
        logic [23:0] usec;
        t_byte       tail;
        first = track_q.size();
        if (e.command) begin
            put_track_byte(ZERO_BYTE);
            put_track_byte(META_PREFIX);
            put_track_byte(META_EOT);
            put_track_byte(ZERO_BYTE);
            cursor_tick = '0;
        end else begin
            if (e.has_metre) begin
                put_delta_vlq(e.tick - cursor_tick);
                cursor_tick = e.tick;
                put_track_byte(META_PREFIX);
                put_track_byte(META_TIME_SIG);
                put_track_byte(TIME_SIG_LEN);
                put_track_byte(e.numerator);
                put_track_byte(denom_exponent(e.denominator));
                put_track_byte(MIDI_CLOCKS);
                put_track_byte(THIRTYSECONDS);
            end
            if (e.has_tempo) begin
                usec = tempo_usec(e.tempo_bpm);
                // delta is zero when the metre was just written
                put_delta_vlq(e.tick - cursor_tick);
                cursor_tick = e.tick;
                put_track_byte(META_PREFIX);
                put_track_byte(META_TEMPO);
                put_track_byte(TEMPO_LEN);
                put_track_byte(usec[23:16]);
                put_track_byte(usec[15:8]);
                put_track_byte(usec[7:0]);
            end
        end
        if (track_q.size() > first) begin
            tail = track_q[track_q.size() - 1];
            tail.last = 1'b1;
            track_q[track_q.size() - 1] = tail;
        end
    endfunction

    // ---------------- stimulus ----------------

    function automatic t_evt make_event(input logic cmd, input logic [31:0] tick,
                                        input logic metre, input logic [7:0] num,
                                        input logic [7:0] den, input logic tempo,
                                        input logic [BPM_W-1:0] bpm);
        t_evt e;
        e.command = cmd;
        e.tick = tick;
        e.has_metre = metre;
        e.numerator = num;
        e.denominator = den;
        e.has_tempo = tempo;
        e.tempo_bpm = bpm;
        return e;
    endfunction

    // valid stays high back to back unless a gap is drawn
    task automatic send_event(input t_evt e);
        int gap;
        gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 14) : 0;
        @(negedge clk);
        if (gap > 0) begin
            evt_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        evt_if.valid <= 1'b1;
        evt_if.payload <= e;
        do @(posedge clk); while (!evt_if.ready);
        encode_event(e);
        last_tick = e.tick;
    endtask

    task automatic test_end_of_track();
        // other fields are ignored by an end command
        send_event(make_event(1'b1, 32'hDEAD_BEEF, 1'b1, 8'hFF, 8'hFF, 1'b1, 10'h3FF));
    endtask

    task automatic test_time_signature();
        send_event(make_event(1'b0, cursor_tick, 1'b1, 8'd0, 8'd0, 1'b0, 10'd0));
        send_event(make_event(1'b0, cursor_tick + 32'h7F, 1'b1, 8'd255, 8'd1, 1'b0, 10'd0));
        send_event(make_event(1'b0, cursor_tick + 32'h80, 1'b1, 8'd3, 8'd2, 1'b0, 10'd0));
        send_event(make_event(1'b0, cursor_tick + 32'h3FFF, 1'b1, 8'd7, 8'd255, 1'b0, 10'd0));
        send_event(make_event(1'b0, cursor_tick + 32'h4000, 1'b1, 8'd12, 8'd128, 1'b0,
                              10'd0));
    endtask

    task automatic test_tempo();
        // zero and very slow tempos saturate
        send_event(make_event(1'b0, cursor_tick + 32'h1F_FFFF, 1'b0, 8'd0, 8'd4, 1'b1, 10'd0));
        send_event(make_event(1'b0, cursor_tick + 32'h20_0000, 1'b0, 8'd0, 8'd4, 1'b1, 10'd1));
        send_event(make_event(1'b0, cursor_tick + 32'h0FFF_FFFF, 1'b0, 8'd0, 8'd4, 1'b1,
                              10'd3));
        send_event(make_event(1'b0, cursor_tick + 32'h1000_0000, 1'b0, 8'd0, 8'd4, 1'b1,
                              10'd4));
        send_event(make_event(1'b0, cursor_tick + 32'd5, 1'b0, 8'd0, 8'd4, 1'b1, 10'd10));
        send_event(make_event(1'b0, cursor_tick + 32'd1, 1'b0, 8'd0, 8'd4, 1'b1, 10'd999));
        send_event(make_event(1'b0, cursor_tick, 1'b0, 8'd0, 8'd4, 1'b1, 10'd1023));
        send_event(make_event(1'b0, cursor_tick + 32'd480, 1'b0, 8'd0, 8'd4, 1'b1, 10'd120));
    endtask

    task automatic test_metre_and_tempo();
        // all-ones delta gives the longest vlq
        send_event(make_event(1'b0, cursor_tick + 32'hFFFF_FFFF, 1'b1, 8'hAA, 8'h55, 1'b1,
                              10'd512));
        send_event(make_event(1'b0, cursor_tick, 1'b1, 8'h55, 8'h08, 1'b1, 10'd341));
    endtask

    task automatic test_empty_and_wrap();
        send_event(make_event(1'b0, 32'hFFFF_FFF0, 1'b0, 8'hFF, 8'hFF, 1'b0, 10'h3FF));
        send_event(make_event(1'b0, cursor_tick - 32'd1000, 1'b1, 8'd6, 8'd8, 1'b0, 10'd0));
        send_event(make_event(1'b1, 32'd0, 1'b0, 8'd0, 8'd0, 1'b0, 10'd0));
        send_event(make_event(1'b0, 32'h8000_0000, 1'b0, 8'd0, 8'd0, 1'b1, 10'd60));
    endtask

    task automatic test_random_events();
        t_evt        e;
        int          counted;
        int          kind;
        int          pick;
        logic [31:0] tick;
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            idle_on = (counted < RANDOM_ITEMS - CALM_ITEMS);
            pick = $urandom_range(0, 15);
            if (pick == 0) begin
                tick = $urandom();
            end else if (pick == 1) begin
                tick = last_tick + $urandom_range(0, 32'h00FF_FFFF);
            end else begin
                tick = last_tick + $urandom_range(0, 2000);
            end
            kind = $urandom_range(0, 19);
            e = make_event(kind == 0, tick, 1'b0, 8'($urandom_range(0, 255)), 8'd4, 1'b0,
                           10'($urandom_range(10, 999)));
            if (kind >= 2 && kind <= 13) begin
                e.has_metre = 1'b1;
            end
            if (kind >= 8) begin
                e.has_tempo = 1'b1;
            end
            e.denominator = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                        : 8'(1 << $urandom_range(0, 7));
            if ($urandom_range(0, 7) == 0) begin
                e.tempo_bpm = 10'($urandom_range(0, 1023));
            end
            send_event(e);
            if (e.command || e.has_metre || e.has_tempo) begin
                counted++;
            end
        end
    endtask

    task automatic finish_stream();
        @(negedge clk);
        evt_if.valid <= 1'b0;
        while (track_q.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // ---------------- output side ----------------

    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
            byte_if.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 14) - 1;
            byte_if.ready <= 1'b0;
        end else begin
            byte_if.ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        t_byte want;
        if (rst_n && byte_if.valid && byte_if.ready) begin
            if (track_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("byte %0d: unexpected %02h last %0b", byte_count,
                             byte_if.payload.out_byte, byte_if.payload.last);
                end
            end else begin
                want = track_q.pop_front();
                if (byte_if.payload.out_byte !== want.out_byte ||
                    byte_if.payload.last !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("byte %0d: expected %02h last %0b, got %02h last %0b",
                                 byte_count, want.out_byte, want.last,
                                 byte_if.payload.out_byte, byte_if.payload.last);
                    end
                end
            end
            byte_count++;
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk) begin
        if ((evt_if.valid && evt_if.ready) || (byte_if.valid && byte_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        evt_if.valid = 1'b0;
        evt_if.payload = '0;
        byte_if.ready = 1'b0;
        rst_n = 1'b0;
        cursor_tick = '0;
        last_tick = '0;
        idle_on = 1'b1;
        mismatch_count = 0;
        byte_count = 0;
        stall_left = 0;
        quiet_cycles = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_end_of_track();
        test_time_signature();
        test_tempo();
        test_metre_and_tempo();
        test_empty_and_wrap();
        test_random_events();
        finish_stream();

        if (mismatch_count == 0 && track_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: midi_conductor_event_encoder.f
hw/rtl/mce_pkg.sv
hw/rtl/mce_stream_if.sv
hw/rtl/mce_front.sv
hw/rtl/mce_queue.sv
hw/rtl/mce_divider.sv
hw/rtl/mce_back.sv
hw/rtl/midi_conductor_event_encoder.sv
verif/tb_midi_conductor_event_encoder.sv
